@@ rtl/core/sqwenv_pkg.sv @@
// shared types, constants and duty table for the square wave channel
package sqwenv_pkg;

   typedef enum logic [1:0] {
      CMD_TIME    = 2'd0,
      CMD_FRAME   = 2'd1,
      CMD_TRIGGER = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   // configuration register indexes
   localparam logic [2:0] REG_DUTY_SELECT     = 3'd0;
   localparam logic [2:0] REG_FREQUENCY       = 3'd1;
   localparam logic [2:0] REG_LENGTH_ENABLE   = 3'd2;
   localparam logic [2:0] REG_ENVELOPE_UP     = 3'd3;
   localparam logic [2:0] REG_ENVELOPE_PERIOD = 3'd4;
   localparam logic [2:0] REG_INITIAL_VOLUME  = 3'd5;

   localparam logic [6:0]  LENGTH_MAX = 7'd64;
   localparam logic [3:0]  VOLUME_MAX = 4'd15;
   localparam logic [13:0] TIMER_MAX  = 14'h3fff;
   localparam logic [11:0] FREQ_BASE  = 12'd2048;

   typedef struct packed {
      logic [1:0]  duty_select;
      logic [10:0] frequency;
      logic        length_enable;
      logic        envelope_up;
      logic [2:0]  envelope_period;
      logic [3:0]  initial_volume;
   } cfg_type;

   typedef struct packed {
      logic        active;
      logic [6:0]  length_count;
      logic        env_running;
      logic [2:0]  env_countdown;
      logic [3:0]  volume;
      logic [13:0] period_timer;
      logic [2:0]  duty_pos;
   } chan_state_type;

   // duty waveforms, bit 7 is played first
   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] pat;
      case (sel)
         2'd0:    pat = 8'h01;
         2'd1:    pat = 8'h81;
         2'd2:    pat = 8'h87;
         default: pat = 8'h7e;
      endcase
      return pat[3'd7 - pos];
   endfunction

endpackage

@@ rtl/core/square_wave_channel_with_envelope.sv @@
// top level of the square wave sound channel with length counter and envelope
//
//  channel | ports                       | transfer when
//  --------+-----------------------------+-------------------------------
//  req     | cmd, elapsed, step, length  | req_valid && req_ready
//  rsp     | sample, channel_on          | rsp_valid && rsp_ready
//  csr     | index, write data           | csr_write_en (no wait)
//
// one command per cycle sustained while rsp is not stalled; rsp_valid rises
// after the req transfer once the command has passed the input register
// and then the channel state and result register
// all work for a command is one pass through the update logic
// reset clears channel state, configuration and both valid flags
// a stalled rsp holds its result; req keeps flowing while the input
// register can move on, so ready drops only when both stages are full
module square_wave_channel_with_envelope
   import sqwenv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_elapsed_cycles,
   input  logic [2:0]  req_frame_step,
   input  logic [6:0]  req_length_load,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_sample,
   output logic        rsp_channel_on,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_write_data
);

   // configuration registers
   cfg_type        cfg_ff;
   cfg_type        cfg_in;

   // input stage
   logic           in_valid_ff;
   logic           in_valid_in;
   cmd_type        cmd_ff;
   logic [7:0]     elapsed_ff;
   logic [2:0]     step_ff;
   logic [6:0]     length_ff;

   // channel state
   chan_state_type state_ff;
   chan_state_type state_in;

   // result stage
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [3:0]     sample_ff;
   logic           on_ff;

   logic [3:0]     sample_in;
   logic           on_in;
   logic           advance;
   logic           take_req;

   // the input stage moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   assign in_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // register writes, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_DUTY_SELECT:     cfg_in.duty_select     = csr_write_data[1:0];
            REG_FREQUENCY:       cfg_in.frequency       = csr_write_data;
            REG_LENGTH_ENABLE:   cfg_in.length_enable   = csr_write_data[0];
            REG_ENVELOPE_UP:     cfg_in.envelope_up     = csr_write_data[0];
            REG_ENVELOPE_PERIOD: cfg_in.envelope_period = csr_write_data[2:0];
            REG_INITIAL_VOLUME:  cfg_in.initial_volume  = csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   sqwenv_update u_update (
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .cmd            (cmd_ff),
      .elapsed_cycles (elapsed_ff),
      .frame_step     (step_ff),
      .length_load    (length_ff),
      .nxt            (state_in),
      .sample         (sample_in),
      .channel_on     (on_in)
   );

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take_req) begin
         cmd_ff     <= cmd_type'(req_cmd);
         elapsed_ff <= req_elapsed_cycles;
         step_ff    <= req_frame_step;
         length_ff  <= req_length_load;
      end
      if (advance) begin
         sample_ff <= sample_in;
         on_ff     <= on_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = sample_ff;
   assign rsp_channel_on = on_ff;

endmodule

@@ rtl/core/sqwenv_update.sv @@
// next-state and sample logic for one command of the square wave channel
module sqwenv_update
   import sqwenv_pkg::*;
(
   input  cfg_type        cfg,
   input  chan_state_type cur,
   input  cmd_type        cmd,
   input  logic [7:0]     elapsed_cycles,
   input  logic [2:0]     frame_step,
   input  logic [6:0]     length_load,
   output chan_state_type nxt,
   output logic [3:0]     sample,
   output logic           channel_on
);

   logic [14:0] timer_sum;
   logic [13:0] timer_sat;
   logic [13:0] period;
   logic [6:0]  length_dec;
   logic [2:0]  countdown_dec;

   assign timer_sum     = {1'b0, cur.period_timer} + {7'd0, elapsed_cycles};
   assign timer_sat     = timer_sum[14] ? TIMER_MAX : timer_sum[13:0];
   assign period        = {FREQ_BASE - {1'b0, cfg.frequency}, 2'b00};
   assign length_dec    = (cur.length_count != 7'd0) ? cur.length_count - 7'd1
                                                     : cur.length_count;
   assign countdown_dec = cur.env_countdown - 3'd1;

   always_comb begin
      nxt = cur;
      case (cmd)
         CMD_TIME: begin
            if (cur.active) begin
               if (timer_sat >= period) begin
                  nxt.period_timer = timer_sat - period;
                  nxt.duty_pos     = cur.duty_pos + 3'd1;
               end else begin
                  nxt.period_timer = timer_sat;
               end
            end
         end
         CMD_FRAME: begin
            if (!frame_step[0]) begin
               if (cfg.length_enable) begin
                  nxt.length_count = length_dec;
                  if (length_dec == 7'd0) begin
                     nxt.active = 1'b0;
                  end
               end
            end else if (frame_step == 3'd7 && cur.env_running) begin
               nxt.env_countdown = countdown_dec;
               if (countdown_dec == 3'd0) begin
                  if (cfg.envelope_up) begin
                     if (cur.volume != VOLUME_MAX) nxt.volume = cur.volume + 4'd1;
                     else                          nxt.env_running = 1'b0;
                  end else begin
                     if (cur.volume != 4'd0) nxt.volume = cur.volume - 4'd1;
                     else                    nxt.env_running = 1'b0;
                  end
                  nxt.env_countdown = cfg.envelope_period;
               end
            end
         end
         CMD_TRIGGER: begin
            nxt.active        = 1'b1;
            nxt.length_count  = (length_load == 7'd0 || length_load > LENGTH_MAX)
                                ? LENGTH_MAX : length_load;
            nxt.volume        = cfg.initial_volume;
            nxt.env_countdown = cfg.envelope_period;
            nxt.env_running   = 1'b1;
            nxt.period_timer  = '0;
         end
         default: begin
         end
      endcase
   end

   // sample from the state after this command
   assign channel_on = nxt.active;
   assign sample     = (nxt.active && duty_bit(cfg.duty_select, nxt.duty_pos))
                       ? nxt.volume : 4'd0;

endmodule

@@ rtl/core/sqwenv_checker.sv @@
// port-level checks for the square wave channel, bound to the top level
module sqwenv_checker
   import sqwenv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_cmd,
   input logic [7:0]  req_elapsed_cycles,
   input logic [2:0]  req_frame_step,
   input logic [6:0]  req_length_load,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_sample,
   input logic        rsp_channel_on,
   input logic        csr_write_en,
   input logic [2:0]  csr_index,
   input logic [10:0] csr_write_data
);

   // a stalled result stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample) && $stable(rsp_channel_on))
      else $error("rsp payload changed while stalled");

   // a disabled channel is silent
   a_off_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_channel_on |-> rsp_sample == 4'd0)
      else $error("nonzero sample from disabled channel");

   // input back-pressure only comes from a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without rsp stall");

   // nothing offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind square_wave_channel_with_envelope sqwenv_checker u_sqwenv_checker (.*);
